>>> hw/rtl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types, function codes and sigmoid breakpoint generation for the
// activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

    localparam int DATA_W             = 16;
    localparam int GUARD_BITS         = 4;
    localparam int FRAC_BITS_DEF      = 12;
    localparam int TABLE_SEGMENTS_DEF = 64;
    localparam int FSEL_W             = 3;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    localparam logic [FSEL_W-1:0] FN_SIGMOID  = 3'd0;
    localparam logic [FSEL_W-1:0] FN_RELU     = 3'd1;
    localparam logic [FSEL_W-1:0] FN_TANH     = 3'd2;
    localparam logic [FSEL_W-1:0] FN_DSIGMOID = 3'd3;
    localparam logic [FSEL_W-1:0] FN_DRELU    = 3'd4;
    localparam logic [FSEL_W-1:0] FN_DTANH    = 3'd5;

    localparam logic REG_FUNC_SEL = 1'b0;

    localparam logic [63:0] Q31_ONE = 64'h8000_0000;

    typedef struct packed {
        logic [FSEL_W-1:0] fsel;
        logic              neg;
        logic [DATA_W-1:0] op;
    } t_ctl;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-y, y in [0,1], 31 fraction bits
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = Q31_ONE;
        term = Q31_ONE;
        for (int n = 1; n <= 20; n++) begin
            term = udiv64((term * y) >> 31, 64'(n));
            sum  = sum + term;
        end
        return udiv64(64'd1 << 62, sum);
    endfunction

    // sigmoid at breakpoint k with frac+GUARD_BITS fraction bits
    function automatic logic [63:0] table_entry(input int k, input int frac, input int segs);
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] em;
        logic [63:0] e1;
        logic [63:0] s;
        int          tb;
        w  = udiv64(64'd32768, 64'(segs));
        t  = 64'(k) * w;
        q  = t >> frac;
        r  = t & ((64'd1 << frac) - 64'd1);
        em = exp_neg_q31(r << (31 - frac));
        e1 = exp_neg_q31(Q31_ONE);
        for (int i = 0; i < 256; i++) begin
            if (64'(i) < q) begin
                em = (em * e1) >> 31;
            end
        end
        s  = udiv64(64'd1 << 62, Q31_ONE + em);
        tb = frac + GUARD_BITS;
        return (s + (64'd1 << (30 - tb))) >> (31 - tb);
    endfunction

endpackage

>>> hw/rtl/nau_cfg.sv
// ----------------------------------------------------------------------------
// nau_cfg
// APB register block holding the function select.
// ----------------------------------------------------------------------------
module nau_cfg
    import nau_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [FSEL_W-1:0]     o_fsel
);

    logic [FSEL_W-1:0] r_fsel;
    logic              wr_sel;

    assign wr_sel = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_FUNC_SEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel <= FN_SIGMOID;
        end else if (wr_sel) begin
            r_fsel <= pwdata[FSEL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_FUNC_SEL) begin
            prdata = APB_DATA_W'(r_fsel);
        end
    end

    assign pready = 1'b1;
    assign o_fsel = r_fsel;

endmodule

>>> hw/rtl/nau_index.sv
// ----------------------------------------------------------------------------
// nau_index
// Magnitude, argument doubling for tanh, and segment index by reciprocal
// multiply with one correction step. Two register stages.
// ----------------------------------------------------------------------------
module nau_index
    import nau_pkg::*;
#(
    parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF,
    localparam int SEG_W = 32768 / TABLE_SEGMENTS,
    localparam int LAST  = 2 * TABLE_SEGMENTS,
    localparam int IDX_W = $clog2(LAST + 1),
    localparam int D_W   = $clog2(SEG_W)
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_operand,
    input  logic [FSEL_W-1:0]        i_fsel,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_ctl                     o_ctl,
    output logic [IDX_W-1:0]         o_idx,
    output logic [D_W-1:0]           o_d,
    output logic                     o_sat
);

    localparam int          MAG_W  = DATA_W + 1;
    localparam int          REC_W  = 34 - $clog2(SEG_W);
    localparam int          QW     = 18 - $clog2(SEG_W);
    localparam int          PROD_W = MAG_W + REC_W;
    localparam logic [63:0] RECIP  = (64'd1 << 32) / SEG_W;

    logic              en1;
    logic              en2;
    logic              tanh_kind;
    logic [MAG_W-1:0]  ext;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  n_m1;
    logic [PROD_W-1:0] n_prod1;
    t_ctl              n_ctl1;

    logic              r_v1;
    t_ctl              r_ctl1;
    logic [MAG_W-1:0]  r_m1;
    logic [PROD_W-1:0] r_prod1;

    logic [QW-1:0]     est;
    logic [MAG_W-1:0]  base;
    logic [MAG_W-1:0]  rem;
    logic              fix;
    logic [QW-1:0]     quo;
    logic [MAG_W-1:0]  drem;
    logic              n_sat2;

    logic              r_v2;
    t_ctl              r_ctl2;
    logic [IDX_W-1:0]  r_idx2;
    logic [D_W-1:0]    r_d2;
    logic              r_sat2;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        tanh_kind   = (i_fsel == FN_TANH) || (i_fsel == FN_DTANH);
        ext         = {i_operand[DATA_W-1], i_operand};
        mag         = i_operand[DATA_W-1] ? (MAG_W'(0) - ext) : ext;
        n_m1        = tanh_kind ? {mag[DATA_W-1:0], 1'b0} : mag;
        n_prod1     = PROD_W'(n_m1) * PROD_W'(RECIP[REC_W-1:0]);
        n_ctl1.fsel = i_fsel;
        n_ctl1.neg  = i_operand[DATA_W-1];
        n_ctl1.op   = i_operand;
    end

    always_comb begin
        est    = r_prod1[32 +: QW];
        base   = MAG_W'(est) * MAG_W'(SEG_W);
        rem    = r_m1 - base;
        fix    = rem >= MAG_W'(SEG_W);
        quo    = fix ? est + QW'(1) : est;
        drem   = fix ? rem - MAG_W'(SEG_W) : rem;
        n_sat2 = quo >= QW'(LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ctl1  <= n_ctl1;
            r_m1    <= n_m1;
            r_prod1 <= n_prod1;
        end
        if (en2) begin
            r_ctl2 <= r_ctl1;
            r_sat2 <= n_sat2;
            r_idx2 <= n_sat2 ? IDX_W'(LAST) : quo[IDX_W-1:0];
            r_d2   <= n_sat2 ? '0 : drem[D_W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;
    assign o_idx   = r_idx2;
    assign o_d     = r_d2;
    assign o_sat   = r_sat2;

    a_d_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (32'(r_d2) < SEG_W))
        else $error("segment offset out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (32'(r_idx2) <= LAST))
        else $error("segment index beyond last breakpoint");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_sat2) |-> ((r_idx2 == IDX_W'(LAST)) && (r_d2 == '0)))
        else $error("saturated request not clamped to last breakpoint");

endmodule

>>> hw/rtl/nau_interp.sv
// ----------------------------------------------------------------------------
// nau_interp
// Breakpoint lookup and linear interpolation of the sigmoid at guard
// precision. Three register stages.
// ----------------------------------------------------------------------------
module nau_interp
    import nau_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF,
    localparam int SEG_W = 32768 / TABLE_SEGMENTS,
    localparam int LAST  = 2 * TABLE_SEGMENTS,
    localparam int IDX_W = $clog2(LAST + 1),
    localparam int D_W   = $clog2(SEG_W),
    localparam int ENT_W = FRAC_BITS + GUARD_BITS + 1
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_ctl             i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [D_W-1:0]   i_d,
    input  logic             i_sat,
    output logic             o_valid,
    input  logic             i_ready,
    output t_ctl             o_ctl,
    output logic [ENT_W-1:0] o_v
);

    localparam int          N_ENT = LAST + 1;
    localparam int          PW    = ENT_W + D_W;
    localparam int          REC_W = 34 - $clog2(SEG_W);
    localparam int          QPW   = PW + REC_W;
    localparam logic [63:0] RECIP = (64'd1 << 32) / SEG_W;

    logic [ENT_W-1:0] seg_tbl [N_ENT];

    for (genvar k = 0; k < N_ENT; k++) begin : g_tbl
        localparam logic [63:0] EV = table_entry(k, FRAC_BITS, TABLE_SEGMENTS);
        assign seg_tbl[k] = EV[ENT_W-1:0];
    end

    logic             en3;
    logic             en4;
    logic             en5;
    logic [IDX_W-1:0] idx1;
    logic [ENT_W-1:0] e0;
    logic [ENT_W-1:0] e1;
    logic [ENT_W-1:0] delta;
    logic [PW-1:0]    n_p3;

    logic             r_v3;
    t_ctl             r_ctl3;
    logic [ENT_W-1:0] r_e0_3;
    logic [PW-1:0]    r_p3;

    logic             r_v4;
    t_ctl             r_ctl4;
    logic [ENT_W-1:0] r_e0_4;
    logic [PW-1:0]    r_p4;
    logic [QPW-1:0]   r_qp4;

    logic [ENT_W-1:0] qe;
    logic [PW-1:0]    base;
    logic [PW-1:0]    rem;
    logic [ENT_W-1:0] quo;
    logic [ENT_W-1:0] n_v5;

    logic             r_v5;
    t_ctl             r_ctl5;
    logic [ENT_W-1:0] r_v5_val;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    always_comb begin
        idx1  = i_sat ? i_idx : i_idx + IDX_W'(1);
        e0    = seg_tbl[i_idx];
        e1    = seg_tbl[idx1];
        delta = e1 - e0;
        n_p3  = PW'(delta) * PW'(i_d);
    end

    always_comb begin
        qe   = r_qp4[32 +: ENT_W];
        base = PW'(qe) * PW'(SEG_W);
        rem  = r_p4 - base;
        quo  = (rem >= PW'(SEG_W)) ? qe + ENT_W'(1) : qe;
        n_v5 = r_e0_4 + quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ctl3 <= i_ctl;
            r_e0_3 <= e0;
            r_p3   <= n_p3;
        end
        if (en4) begin
            r_ctl4 <= r_ctl3;
            r_e0_4 <= r_e0_3;
            r_p4   <= r_p3;
            r_qp4  <= QPW'(r_p3) * QPW'(RECIP[REC_W-1:0]);
        end
        if (en5) begin
            r_ctl5   <= r_ctl4;
            r_v5_val <= n_v5;
        end
    end

    assign o_valid = r_v5;
    assign o_ctl   = r_ctl5;
    assign o_v     = r_v5_val;

endmodule

>>> hw/rtl/nau_post.sv
// ----------------------------------------------------------------------------
// nau_post
// Sign handling and rounding to the output format, then function select
// and derivative products. Two register stages, the last one is the
// output register.
// ----------------------------------------------------------------------------
module nau_post
    import nau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int ENT_W = FRAC_BITS + GUARD_BITS + 1
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_ctl                     i_ctl,
    input  logic [ENT_W-1:0]         i_v,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_act
);

    localparam int TB  = FRAC_BITS + GUARD_BITS;
    localparam int G_W = ENT_W + 1;
    localparam int U_W = FRAC_BITS + 1;
    localparam int M_W = 2 * U_W;

    localparam logic [ENT_W-1:0]  ONE_E = ENT_W'(1) << TB;
    localparam logic [G_W-1:0]    ONE_G = G_W'(1) << TB;
    localparam logic [G_W-1:0]    RND_G = G_W'(1) << (GUARD_BITS - 1);
    localparam logic [U_W-1:0]    ONE_U = U_W'(1) << FRAC_BITS;
    localparam logic [M_W-1:0]    RND_M = M_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] ONE_D = DATA_W'(1) << FRAC_BITS;

    logic              en6;
    logic              en7;
    logic              sig_kind;
    logic [ENT_W-1:0]  sg;
    logic [G_W-1:0]    tw;
    logic [G_W-1:0]    tg;
    logic [G_W-1:0]    g;
    logic [G_W-1:0]    gr;
    logic [U_W-1:0]    n_u6;

    logic              r_v6;
    t_ctl              r_ctl6;
    logic [U_W-1:0]    r_u6;

    logic              pos;
    logic [U_W-1:0]    mul_b;
    logic [M_W-1:0]    mul;
    logic [M_W-1:0]    mul_r;
    logic [DATA_W-1:0] u16;
    logic [DATA_W-1:0] n_act7;

    logic              r_v7;
    logic [DATA_W-1:0] r_act7;

    assign en7     = !r_v7 || i_ready;
    assign en6     = !r_v6 || en7;
    assign o_ready = en6;

    always_comb begin
        sig_kind = (i_ctl.fsel == FN_SIGMOID) || (i_ctl.fsel == FN_DSIGMOID);
        sg       = i_ctl.neg ? (ONE_E - i_v) : i_v;
        tw       = {i_v, 1'b0};
        tg       = (tw > ONE_G) ? (tw - ONE_G) : '0;
        g        = sig_kind ? G_W'(sg) : tg;
        gr       = (g + RND_G) >> GUARD_BITS;
        n_u6     = gr[U_W-1:0];
    end

    always_comb begin
        pos    = !r_ctl6.op[DATA_W-1] && (r_ctl6.op != '0);
        mul_b  = (r_ctl6.fsel == FN_DSIGMOID) ? (ONE_U - r_u6) : r_u6;
        mul    = M_W'(r_u6) * M_W'(mul_b);
        mul_r  = (mul + RND_M) >> FRAC_BITS;
        u16    = DATA_W'(r_u6);
        case (r_ctl6.fsel)
            FN_SIGMOID:  n_act7 = u16;
            FN_RELU:     n_act7 = pos ? r_ctl6.op : '0;
            FN_TANH:     n_act7 = r_ctl6.neg ? (DATA_W'(0) - u16) : u16;
            FN_DSIGMOID: n_act7 = mul_r[DATA_W-1:0];
            FN_DRELU:    n_act7 = pos ? ONE_D : '0;
            FN_DTANH:    n_act7 = ONE_D - mul_r[DATA_W-1:0];
            default:     n_act7 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (en6) begin
                r_v6 <= i_valid;
            end
            if (en7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_ctl6 <= i_ctl;
            r_u6   <= n_u6;
        end
        if (en7) begin
            r_act7 <= n_act7;
        end
    end

    assign o_valid = r_v7;
    assign o_act   = $signed(r_act7);

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |-> (r_u6 <= ONE_U))
        else $error("rounded sigmoid or tanh above one");

    a_drelu_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && en7 && (r_ctl6.fsel == FN_DRELU)) |=> ((r_act7 == '0) || (r_act7 == ONE_D)))
        else $error("relu derivative neither zero nor one");

    a_dsig_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && en7 && (r_ctl6.fsel == FN_DSIGMOID)) |=> (r_act7 <= (ONE_D >> 2)))
        else $error("sigmoid derivative above one quarter");

endmodule

>>> hw/rtl/neural_activation_unit.sv
// ----------------------------------------------------------------------------
// neural_activation_unit
// Element-wise activation on signed fixed-point values: sigmoid, relu, tanh
// and their derivatives, selected through the APB function select register.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled, and returns
// one result per request, in order. A request passes through seven register
// stages, the first of which captures it: magnitude and reciprocal multiply,
// segment correction, breakpoint read and slope multiply, reciprocal
// multiply of the slope product, interpolation add, rounding, and the
// derivative multiply feeding the output register. Backpressure stalls only
// the stages that are full, so the input keeps taking requests until the
// pipeline is full. Write the function select only while no request is in
// flight.
// ----------------------------------------------------------------------------
module neural_activation_unit
    import nau_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic signed [DATA_W-1:0] s_axis_tdata,  // [15:0] operand
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic signed [DATA_W-1:0] m_axis_tdata,  // [15:0] activation
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready
);

    localparam int SEG_W = 32768 / TABLE_SEGMENTS;
    localparam int LAST  = 2 * TABLE_SEGMENTS;
    localparam int IDX_W = $clog2(LAST + 1);
    localparam int D_W   = $clog2(SEG_W);
    localparam int ENT_W = FRAC_BITS + GUARD_BITS + 1;

    logic [FSEL_W-1:0] fsel;

    logic              ix_valid;
    logic              ix_ready;
    t_ctl              ix_ctl;
    logic [IDX_W-1:0]  ix_idx;
    logic [D_W-1:0]    ix_d;
    logic              ix_sat;

    logic              ip_valid;
    logic              ip_ready;
    t_ctl              ip_ctl;
    logic [ENT_W-1:0]  ip_v;

    nau_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_fsel  (fsel)
    );

    nau_index #(
        .TABLE_SEGMENTS (TABLE_SEGMENTS)
    ) u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_operand (s_axis_tdata),
        .i_fsel    (fsel),
        .o_valid   (ix_valid),
        .i_ready   (ix_ready),
        .o_ctl     (ix_ctl),
        .o_idx     (ix_idx),
        .o_d       (ix_d),
        .o_sat     (ix_sat)
    );

    nau_interp #(
        .FRAC_BITS      (FRAC_BITS),
        .TABLE_SEGMENTS (TABLE_SEGMENTS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ix_valid),
        .o_ready (ix_ready),
        .i_ctl   (ix_ctl),
        .i_idx   (ix_idx),
        .i_d     (ix_d),
        .i_sat   (ix_sat),
        .o_valid (ip_valid),
        .i_ready (ip_ready),
        .o_ctl   (ip_ctl),
        .o_v     (ip_v)
    );

    nau_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ip_valid),
        .o_ready (ip_ready),
        .i_ctl   (ip_ctl),
        .i_v     (ip_v),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_act   (m_axis_tdata)
    );

endmodule
